>>> sv/owbm_pkg.sv
`timescale 1ns / 1ps

package owbm_pkg;

	// Counter width default and configuration register geometry.
	localparam int COUNT_WIDTH_DEF = 10;
	localparam int CFG_W           = 10;
	localparam int NUM_REGS        = 7;
	localparam int PADDR_W         = 5;
	localparam int PDATA_W         = 32;
	localparam int REG_IDX_W       = 3;

	// Register indexes on the configuration port.
	localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SHORT_LOW     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LONG_LOW      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_DELAY  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SLOT          = 3'd6;

	// Register reset values, in ticks.
	localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd480;
	localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd70;
	localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 10'd410;
	localparam logic [CFG_W-1:0] RST_SHORT_LOW     = 10'd6;
	localparam logic [CFG_W-1:0] RST_LONG_LOW      = 10'd60;
	localparam logic [CFG_W-1:0] RST_SAMPLE_DELAY  = 10'd9;
	localparam logic [CFG_W-1:0] RST_SLOT          = 10'd70;

	// Smallest usable timing values.
	localparam logic [CFG_W-1:0] MIN_TIMING = 10'd1;
	localparam logic [CFG_W-1:0] MIN_SLOT   = 10'd2;

	// Command codes.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Index of the last bit of a byte.
	localparam logic [2:0] BIT_LAST = 3'd7;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_WAIT = 3'd2,
		PH_RST_TAIL = 3'd3,
		PH_WRITE    = 3'd4,
		PH_READ     = 3'd5
	} phase_t;

	// Timing registers as seen by the sequencer.
	typedef struct packed {
		logic [CFG_W-1:0] reset_low;
		logic [CFG_W-1:0] presence_wait;
		logic [CFG_W-1:0] reset_tail;
		logic [CFG_W-1:0] short_low;
		logic [CFG_W-1:0] long_low;
		logic [CFG_W-1:0] sample_delay;
		logic [CFG_W-1:0] slot;
	} cfg_t;

	// Result of one tick.
	typedef struct packed {
		logic       drive_low;
		logic       busy;
		logic       done;
		logic       presence;
		logic [7:0] rx_byte;
		logic       rejected;
	} res_t;

endpackage

>>> sv/one_wire_bus_master_core.sv
`timescale 1ns / 1ps
// Path: a tick request passes the input register, then the result register.
// Throughput: one tick request per cycle while out_stall does not hold the result;
// the sequencer state advances once per accepted request.
// Reset: timing registers return to their defaults, the sequencer goes idle with
// presence and the read byte cleared, and both pipeline stages empty.

module one_wire_bus_master_core
	import owbm_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Tick request channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [7:0]         tx_byte,
	input  logic               bus_sense,
	// Result channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic               drive_low,
	output logic               busy_res,
	output logic               done_res,
	output logic               presence,
	output logic [7:0]         rx_byte,
	output logic               rejected,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t       cfg;
	res_t       step_res;
	res_t       res_q;
	logic       s1_valid_q;
	logic [1:0] opcode_s1;
	logic [7:0] tx_byte_s1;
	logic       bus_sense_s1;
	logic       out_valid_q;
	logic       out_free;
	logic       s1_move;

	owbm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	owbm_sequencer #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (s1_move),
		.opcode    (opcode_s1),
		.tx_byte   (tx_byte_s1),
		.bus_sense (bus_sense_s1),
		.cfg       (cfg),
		.res       (step_res)
	);

	// Handshake: stage one drains whenever the result register can take a result.
	assign out_free = !out_valid_q || !out_stall;
	assign s1_move  = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) s1_valid_q <= in_valid;
			if (out_free) out_valid_q <= s1_valid_q;
		end
	end

	// Payload of both stages.
	always_ff @(posedge clk) begin
		if (!in_stall) begin
			opcode_s1    <= opcode;
			tx_byte_s1   <= tx_byte;
			bus_sense_s1 <= bus_sense;
		end
		if (s1_move) res_q <= step_res;
	end

	assign out_valid = out_valid_q;
	assign drive_low = res_q.drive_low;
	assign busy_res  = res_q.busy;
	assign done_res  = res_q.done;
	assign presence  = res_q.presence;
	assign rx_byte   = res_q.rx_byte;
	assign rejected  = res_q.rejected;

	// A completed command was busy on its last tick.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done |-> res_q.busy)
		else $error("done without busy");

	// A rejection can only happen while a command is running.
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.rejected |-> res_q.busy)
		else $error("rejected while idle");

	// The line is only pulled low by a running command.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.drive_low |-> res_q.busy)
		else $error("bus driven while idle");

	// A request held in stage one is never dropped.
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_move |=> s1_valid_q)
		else $error("stage one request lost");

endmodule

>>> sv/owbm_cfg_regs.sv
`timescale 1ns / 1ps

module owbm_cfg_regs
	import owbm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	logic [CFG_W-1:0]     wr_val;
	logic [CFG_W-1:0]     rd_val;
	cfg_t                 cfg_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign wr_val  = pwdata[CFG_W-1:0];
	assign cfg     = cfg_q;

	// Register writes; addresses past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low     <= RST_RESET_LOW;
			cfg_q.presence_wait <= RST_PRESENCE_WAIT;
			cfg_q.reset_tail    <= RST_RESET_TAIL;
			cfg_q.short_low     <= RST_SHORT_LOW;
			cfg_q.long_low      <= RST_LONG_LOW;
			cfg_q.sample_delay  <= RST_SAMPLE_DELAY;
			cfg_q.slot          <= RST_SLOT;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RESET_LOW:     cfg_q.reset_low     <= wr_val;
				REG_PRESENCE_WAIT: cfg_q.presence_wait <= wr_val;
				REG_RESET_TAIL:    cfg_q.reset_tail    <= wr_val;
				REG_SHORT_LOW:     cfg_q.short_low     <= wr_val;
				REG_LONG_LOW:      cfg_q.long_low      <= wr_val;
				REG_SAMPLE_DELAY:  cfg_q.sample_delay  <= wr_val;
				REG_SLOT:          cfg_q.slot          <= wr_val;
				default: begin
				end
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (reg_idx)
			REG_RESET_LOW:     rd_val = cfg_q.reset_low;
			REG_PRESENCE_WAIT: rd_val = cfg_q.presence_wait;
			REG_RESET_TAIL:    rd_val = cfg_q.reset_tail;
			REG_SHORT_LOW:     rd_val = cfg_q.short_low;
			REG_LONG_LOW:      rd_val = cfg_q.long_low;
			REG_SAMPLE_DELAY:  rd_val = cfg_q.sample_delay;
			REG_SLOT:          rd_val = cfg_q.slot;
			default:           rd_val = '0;
		endcase
	end

	assign prdata = {{(PDATA_W-CFG_W){1'b0}}, rd_val};

endmodule

>>> sv/owbm_sequencer.sv
`timescale 1ns / 1ps

module owbm_sequencer
	import owbm_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [1:0] opcode,
	input  logic [7:0] tx_byte,
	input  logic       bus_sense,
	input  cfg_t       cfg,
	output res_t       res
);

	localparam int                VW        = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
	localparam logic [VW-1:0]     CNT_MAX_V = VW'((1 << COUNT_WIDTH) - 1);
	localparam logic [COUNT_WIDTH:0] ONE_W  = (COUNT_WIDTH+1)'(1);

	// Clamp a timing register to its floor and to the counter range.
	function automatic logic [COUNT_WIDTH-1:0] lim_val(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] floor_v);
		logic [VW-1:0] x;
		x = VW'(v);
		if (x < VW'(floor_v)) x = VW'(floor_v);
		if (x > CNT_MAX_V) x = CNT_MAX_V;
		return x[COUNT_WIDTH-1:0];
	endfunction

	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] tick_q, tick_d;
	logic [2:0]             bit_idx_q, bit_idx_d;
	logic [7:0]             shift_q, shift_d;
	logic                   presence_q, presence_d;
	logic [7:0]             rx_q, rx_d;

	logic [COUNT_WIDTH-1:0] len_rst_low, len_wait, len_tail;
	logic [COUNT_WIDTH-1:0] len_short, len_long, len_slot, len_delay;
	logic [COUNT_WIDTH-1:0] slot_m1, sample_at, period_len;
	logic [COUNT_WIDTH:0]   sample_sum, tick_inc;
	logic                   period_end;
	logic                   tx_lsb;

	// Effective timing values.
	always_comb begin
		len_rst_low = lim_val(cfg.reset_low, MIN_TIMING);
		len_wait    = lim_val(cfg.presence_wait, MIN_TIMING);
		len_tail    = lim_val(cfg.reset_tail, MIN_TIMING);
		len_short   = lim_val(cfg.short_low, MIN_TIMING);
		len_long    = lim_val(cfg.long_low, MIN_TIMING);
		len_delay   = lim_val(cfg.sample_delay, MIN_TIMING);
		len_slot    = lim_val(cfg.slot, MIN_SLOT);
		slot_m1     = len_slot - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
		sample_sum  = {1'b0, len_short} + {1'b0, len_delay};
		sample_at   = (sample_sum > {1'b0, slot_m1}) ? slot_m1 : sample_sum[COUNT_WIDTH-1:0];
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			tick_q     <= '0;
			bit_idx_q  <= '0;
			shift_q    <= '0;
			presence_q <= 1'b0;
			rx_q       <= '0;
		end else if (step_en) begin
			phase_q    <= phase_d;
			tick_q     <= tick_d;
			bit_idx_q  <= bit_idx_d;
			shift_q    <= shift_d;
			presence_q <= presence_d;
			rx_q       <= rx_d;
		end
	end

	// Next state and result for one tick.
	always_comb begin
		phase_d    = phase_q;
		tick_d     = tick_q;
		bit_idx_d  = bit_idx_q;
		shift_d    = shift_q;
		presence_d = presence_q;
		rx_d       = rx_q;
		res        = '0;

		// Command start when idle, rejection of a command while one is running.
		if (phase_q == PH_IDLE) begin
			if (opcode != OP_TICK) begin
				tick_d    = '0;
				bit_idx_d = '0;
				shift_d   = '0;
				case (opcode)
					OP_RESET: phase_d = PH_RST_LOW;
					OP_WRITE: begin
						phase_d = PH_WRITE;
						shift_d = tx_byte;
					end
					default:  phase_d = PH_READ;
				endcase
			end
		end else if (opcode != OP_TICK) begin
			res.rejected = 1'b1;
		end

		res.busy = (phase_d != PH_IDLE);

		// Shared period counter.
		case (phase_d)
			PH_RST_LOW:  period_len = len_rst_low;
			PH_RST_WAIT: period_len = len_wait;
			PH_RST_TAIL: period_len = len_tail;
			default:     period_len = len_slot;
		endcase
		tick_inc   = {1'b0, tick_d} + ONE_W;
		period_end = (tick_inc >= {1'b0, period_len});
		tx_lsb     = shift_d[0];

		case (phase_d)
			PH_IDLE: begin
			end
			PH_RST_LOW: begin
				res.drive_low = 1'b1;
				if (period_end) phase_d = PH_RST_WAIT;
			end
			PH_RST_WAIT: begin
				if (period_end) phase_d = PH_RST_TAIL;
			end
			PH_RST_TAIL: begin
				if (tick_d == '0) presence_d = !bus_sense;
				if (period_end) begin
					phase_d  = PH_IDLE;
					res.done = 1'b1;
				end
			end
			PH_WRITE: begin
				res.drive_low = (tick_d < (tx_lsb ? len_short : len_long));
				if (period_end) begin
					shift_d = {1'b0, shift_d[7:1]};
					if (bit_idx_d == BIT_LAST) begin
						phase_d  = PH_IDLE;
						res.done = 1'b1;
					end else begin
						bit_idx_d = bit_idx_d + 3'd1;
					end
				end
			end
			PH_READ: begin
				res.drive_low = (tick_d < len_short);
				if (tick_d == sample_at) shift_d = {bus_sense, shift_d[7:1]};
				if (period_end) begin
					if (bit_idx_d == BIT_LAST) begin
						rx_d     = shift_d;
						phase_d  = PH_IDLE;
						res.done = 1'b1;
					end else begin
						bit_idx_d = bit_idx_d + 3'd1;
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase

		// The counter runs only while a command is active.
		if (res.busy) tick_d = period_end ? '0 : tick_inc[COUNT_WIDTH-1:0];

		res.presence = presence_d;
		res.rx_byte  = rx_d;
	end

endmodule
